// File: rtl/assert_macros.svh
// Shared assertion macros for the decoder checker.
// Each macro expands to one labelled concurrent assertion, clocked on the rising edge
// and switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define HHT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hht assertion failed");

// A payload must hold while its beat is offered and not taken.
`define HHT_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy) |=> $stable(sig))) \
		else $error("hht payload changed while stalled");

`endif

// File: rtl/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg
// Types and codes shared by the heap-table Huffman decoder and its checker.
// ----------------------------------------------------------------------------
package hht_pkg;

	localparam int PAT_W = 12;
	localparam int LEN_W = 4;
	localparam int SYM_W = 8;
	localparam int BYTE_W = 8;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_EOF_SYMBOL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST = 1'd1;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic [1:0] ST_SYMBOL = 2'd0;
	localparam logic [1:0] ST_END = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [PAT_W-1:0] code_pattern;
		logic [LEN_W-1:0] code_length;
		logic [SYM_W-1:0] symbol_value;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [1:0] status;
		logic last;
	} result_t;

	typedef struct packed {
		logic used;
		logic [SYM_W-1:0] sym;
	} entry_t;

endpackage

// File: rtl/hht_stream_if.sv
// ----------------------------------------------------------------------------
// hht_stream_if
// Valid/ready channel carrying one payload of type T per beat.
// ----------------------------------------------------------------------------
interface hht_stream_if #(parameter type T = logic) ();

	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// File: rtl/hht_ram.sv
// ----------------------------------------------------------------------------
// hht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hht_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 8192
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/huffman_heap_table_decoder_core.sv
// ----------------------------------------------------------------------------
// Data byte: at most one table read per bit; no new item is taken until the walk of the byte
// and the flush of any results are done; result-side stalls hold the walk.
// Loads and ignored items: taken in idle; a clear: a sweep over all 2^(MAX_CODE_LEN+1) entries.
// Reset: asynchronous, active low; afterwards a clearing pass over the whole table.
// ----------------------------------------------------------------------------
module huffman_heap_table_decoder_core #(
	parameter int MAX_CODE_LEN = 12
) (
	input logic clk,
	input logic arst_n,
	hht_stream_if.sink item,
	hht_stream_if.source result,
	input logic cfg_we,
	input logic [hht_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [hht_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = MAX_CODE_LEN + 1;
	localparam int DEPTH = 1 << IW;
	localparam int EW = (IW > hht_pkg::PAT_W) ? IW : hht_pkg::PAT_W;
	localparam int LW = hht_pkg::LEN_W + 1;
	localparam logic [LW-1:0] MaxLen = LW'(MAX_CODE_LEN);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK, S_FLUSH} state_t;

	state_t state_q;
	logic [IW-1:0] tree_q;
	logic done_q;
	logic [hht_pkg::SYM_W-1:0] eof_q;
	logic lsb_q;
	logic [hht_pkg::BYTE_W-2:0] sr_q;
	logic [2:0] cnt_q;
	logic [IW-1:0] addr_q;
	logic ovf_q;
	logic [IW-1:0] clr_q;
	hht_pkg::result_t pend_q;
	logic pv_q;
	hht_pkg::result_t res_q;
	logic rv_q;

	hht_pkg::item_t in_d;
	hht_pkg::entry_t rd_entry;
	hht_pkg::entry_t wr_entry;
	hht_pkg::result_t new_res;
	hht_pkg::result_t res_next;
	logic res_push;
	logic accept;
	logic slot_free;
	logic go;
	logic used;
	logic hit;
	logic is_eof;
	logic final_bit;
	logic len_ok;
	logic [hht_pkg::BYTE_W-1:0] ord;
	logic [IW+1:0] acc_step;
	logic [IW+1:0] walk_step;
	logic [IW-1:0] idx_new;
	logic [EW-1:0] ld_mask;
	logic [EW-1:0] ld_idx;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic [$bits(hht_pkg::entry_t)-1:0] rd_raw;

	// Child of a node in the implicit tree: 2*idx + 1 + bit, kept two bits wider.
	function automatic logic [IW+1:0] step_addr(logic [IW-1:0] idx, logic b);
		return {1'b0, idx, b} + (IW+2)'(1);
	endfunction

	assign in_d = item.data;
	assign item.ready = (state_q == S_IDLE);
	assign accept = item.valid && item.ready;
	assign result.valid = rv_q;
	assign result.data = res_q;
	assign slot_free = !rv_q || result.ready;

	// The byte is reordered once so that the walk always takes its top bit next.
	always_comb begin
		for (int i = 0; i < hht_pkg::BYTE_W; i++) begin
			ord[i] = lsb_q ? in_d.data_byte[hht_pkg::BYTE_W-1-i] : in_d.data_byte[i];
		end
	end

	assign acc_step = step_addr(tree_q, ord[hht_pkg::BYTE_W-1]);

	assign rd_entry = hht_pkg::entry_t'(rd_raw);
	assign used = !ovf_q && rd_entry.used;
	assign hit = ovf_q || used;
	assign is_eof = used && (rd_entry.sym == eof_q);
	assign final_bit = (cnt_q == 3'd7);
	assign go = (state_q == S_WALK) && (!pv_q || slot_free);
	assign idx_new = hit ? '0 : addr_q;
	assign walk_step = step_addr(idx_new, sr_q[hht_pkg::BYTE_W-2]);

	always_comb begin
		new_res.last = 1'b0;
		if (ovf_q) begin
			new_res.status = hht_pkg::ST_INVALID;
			new_res.symbol = '0;
		end else if (is_eof) begin
			new_res.status = hht_pkg::ST_END;
			new_res.symbol = '0;
		end else begin
			new_res.status = hht_pkg::ST_SYMBOL;
			new_res.symbol = rd_entry.sym;
		end
	end

	// The output register takes the held result when a newer one replaces it, or at the flush.
	always_comb begin
		res_push = 1'b0;
		res_next = pend_q;
		if (go && hit && pv_q) begin
			res_push = 1'b1;
		end else if (state_q == S_FLUSH && slot_free) begin
			res_push = 1'b1;
			res_next.last = 1'b1;
		end
	end

	// Heap index of a loaded codeword: 2^len - 1 plus the pattern cut to len bits.
	assign len_ok = (in_d.code_length != '0) && ({1'b0, in_d.code_length} <= MaxLen);
	assign ld_mask = (EW'(1) << in_d.code_length) - EW'(1);
	assign ld_idx = ld_mask + (EW'(in_d.code_pattern) & ld_mask);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = clr_q;
		wr_entry = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (accept && in_d.kind == hht_pkg::KIND_LOAD && len_ok) begin
			wr_en = 1'b1;
			wr_addr = ld_idx[IW-1:0];
			wr_entry.used = 1'b1;
			wr_entry.sym = in_d.symbol_value;
		end
	end

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = acc_step[IW-1:0];
			rd_en = accept && (in_d.kind == hht_pkg::KIND_DATA) && !done_q
				&& !(|acc_step[IW+1:IW]);
		end else begin
			rd_addr = walk_step[IW-1:0];
			rd_en = go && !is_eof && !final_bit && !(|walk_step[IW+1:IW]);
		end
	end

	hht_ram #(
		.WIDTH($bits(hht_pkg::entry_t)),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tree_q <= '0;
			done_q <= 1'b0;
			eof_q <= '0;
			lsb_q <= 1'b0;
			sr_q <= '0;
			cnt_q <= '0;
			addr_q <= '0;
			ovf_q <= 1'b0;
			clr_q <= '0;
			pend_q <= '0;
			pv_q <= 1'b0;
			res_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					hht_pkg::CFG_EOF_SYMBOL: eof_q <= cfg_data[hht_pkg::SYM_W-1:0];
					hht_pkg::CFG_LSB_FIRST: lsb_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (res_push) begin
				res_q <= res_next;
				rv_q <= 1'b1;
			end else if (rv_q && result.ready) begin
				rv_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (in_d.kind)
							hht_pkg::KIND_CLEAR: begin
								clr_q <= '0;
								tree_q <= '0;
								done_q <= 1'b0;
								state_q <= S_CLEAR;
							end
							hht_pkg::KIND_DATA: begin
								if (!done_q) begin
									sr_q <= ord[hht_pkg::BYTE_W-2:0];
									cnt_q <= '0;
									addr_q <= acc_step[IW-1:0];
									ovf_q <= |acc_step[IW+1:IW];
									state_q <= S_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (go) begin
						// A result is held back until the next one or the flush, so that its last flag is known.
						if (hit) begin
							pend_q <= new_res;
							pv_q <= 1'b1;
						end
						if (is_eof) begin
							done_q <= 1'b1;
							tree_q <= '0;
							state_q <= S_FLUSH;
						end else if (final_bit) begin
							tree_q <= idx_new;
							state_q <= (pv_q || hit) ? S_FLUSH : S_IDLE;
						end else begin
							addr_q <= walk_step[IW-1:0];
							ovf_q <= |walk_step[IW+1:IW];
							sr_q <= {sr_q[hht_pkg::BYTE_W-3:0], 1'b0};
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						pv_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/hht_checker.sv
// ----------------------------------------------------------------------------
// hht_checker
// Port-level checks on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hht_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic [1:0] item_kind,
	input logic result_valid,
	input logic result_ready,
	input logic [hht_pkg::SYM_W-1:0] result_symbol,
	input logic [1:0] result_status,
	input logic result_last
);

	// A clear starts the table sweep, so no item can follow straight away.
	`HHT_ASSERT(a_clear_blocks, clk, arst_n, item_valid && item_ready && item_kind == hht_pkg::KIND_CLEAR |=> !item_ready)

	// Decoding stops at the end of stream, so that beat closes its byte.
	`HHT_ASSERT(a_end_is_last, clk, arst_n, result_valid && result_status == hht_pkg::ST_END |-> result_last)

	`HHT_ASSERT(a_zero_symbol, clk, arst_n, result_valid && result_status != hht_pkg::ST_SYMBOL |-> result_symbol == '0)

	`HHT_ASSERT_HOLD(a_result_hold, clk, arst_n, result_valid, result_ready, {result_symbol, result_status, result_last})

endmodule

bind huffman_heap_table_decoder_core hht_checker u_hht_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.item_kind(item.data.kind),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.result_symbol(result.data.symbol),
	.result_status(result.data.status),
	.result_last(result.data.last)
);

// File: test/hht_decode_checker.sv
// ----------------------------------------------------------------------------
// hht_decode_checker
// Passive checker for the heap-table Huffman decoder. It keeps its own copy of
// the code table, the tree walk and the registers. Every item beat it sees
// accepted is decoded here into the results it should cause. Every result beat
// is then compared, field by field, against the oldest of those.
// ----------------------------------------------------------------------------
module hht_decode_checker
	import hht_pkg::*;
#(
	parameter int MAX_CODE_LEN = 12
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input item_t item_beat,
	input logic res_valid,
	input logic res_ready,
	input result_t res_beat,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int mismatches,
	output int pending,
	output int n_sym,
	output int n_end,
	output int n_inv
);

	localparam int NODES = 1 << (MAX_CODE_LEN + 1);

	entry_t code_store [NODES];
	int walk_node;
	bit stream_ended;
	logic [SYM_W-1:0] eof_sym;
	bit lsb_order;
	result_t due_results [$];

	function automatic void wipe_tree();
		foreach (code_store[i]) code_store[i] = '0;
		walk_node = 0;
		stream_ended = 1'b0;
	endfunction

	// Each bit can give at most one result. A result is held back until the next
	// one appears, so that the final one of the byte can carry the last flag.
	function automatic void walk_byte(input logic [BYTE_W-1:0] b);
		int nxt;
		logic bv;
		bit got;
		bit held;
		result_t r;
		result_t held_r;
		held = 1'b0;
		held_r = '0;
		for (int j = 0; j < 8 && !stream_ended; j++) begin
			bv = lsb_order ? b[j] : b[7 - j];
			nxt = 2 * walk_node + 1 + bv;
			got = 1'b0;
			r = '0;
			if (nxt >= NODES) begin
				r.status = ST_INVALID;
				got = 1'b1;
				walk_node = 0;
			end else if (code_store[nxt].used) begin
				walk_node = 0;
				got = 1'b1;
				if (code_store[nxt].sym == eof_sym) begin
					r.status = ST_END;
					stream_ended = 1'b1;
				end else begin
					r.status = ST_SYMBOL;
					r.symbol = code_store[nxt].sym;
				end
			end else begin
				walk_node = nxt;
			end
			if (got) begin
				if (held) due_results.push_back(held_r);
				held_r = r;
				held = 1'b1;
			end
		end
		if (held) begin
			held_r.last = 1'b1;
			due_results.push_back(held_r);
		end
	endfunction

	function automatic void predict_item(input item_t it);
		int span;
		int node;
		case (it.kind)
			KIND_CLEAR: wipe_tree();
			KIND_LOAD: begin
				// Lengths outside 1..MAX_CODE_LEN leave the table alone.
				if (it.code_length != 0 && it.code_length <= MAX_CODE_LEN) begin
					span = 1 << it.code_length;
					node = span - 1 + (int'(it.code_pattern) & (span - 1));
					if (node < NODES) begin
						code_store[node].used = 1'b1;
						code_store[node].sym = it.symbol_value;
					end
				end
			end
			KIND_DATA: begin
				if (!stream_ended) walk_byte(it.data_byte);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_result(input result_t got);
		result_t want;
		case (got.status)
			ST_SYMBOL: n_sym++;
			ST_END: n_end++;
			ST_INVALID: n_inv++;
			default: ;
		endcase
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: symbol %0d status %0d last %0d",
					got.symbol, got.status, got.last);
		end else begin
			want = due_results.pop_front();
			if (got.symbol !== want.symbol || got.status !== want.status
					|| got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected symbol %0d status %0d last %0d, got symbol %0d status %0d last %0d",
						want.symbol, want.status, want.last, got.symbol, got.status, got.last);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_tree();
			eof_sym = '0;
			lsb_order = 1'b0;
			due_results.delete();
			mismatches = 0;
			n_sym = 0;
			n_end = 0;
			n_inv = 0;
		end else begin
			// Results are checked before the new item is decoded; a result never
			// leaves in the cycle its item is accepted.
			if (res_valid && res_ready) check_result(res_beat);
			if (item_valid && item_ready) predict_item(item_beat);
			if (cfg_we) begin
				case (cfg_idx)
					CFG_EOF_SYMBOL: eof_sym = cfg_data[SYM_W-1:0];
					CFG_LSB_FIRST: lsb_order = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending = due_results.size();
	end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for huffman_heap_table_decoder_core. A short directed
// run covers field extremes, ignored items, walks past the table and the end of
// the stream. Random prefix codes are then loaded and streams of their
// codewords decoded, over several register settings, with random idling on
// both channels and some noise.
// ----------------------------------------------------------------------------
module testbench;
	import hht_pkg::*;

	localparam int MAX_LEN = 12;
	localparam int CLEAR_SWEEP = 1 << (MAX_LEN + 1);
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int N_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 50;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	hht_stream_if #(.T(item_t)) item ();
	hht_stream_if #(.T(result_t)) result ();

	int mismatches;
	int pending;
	int n_sym;
	int n_end;
	int n_inv;

	bit calm = 1'b0;
	bit stream_closed = 1'b0;
	int useful_beats = 0;
	int beats_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	logic [1:0] last_kind = KIND_DATA;
	logic [SYM_W-1:0] eof_cur = '0;
	bit lsb_cur = 1'b0;

	huffman_heap_table_decoder_core #(.MAX_CODE_LEN(MAX_LEN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	hht_decode_checker #(.MAX_CODE_LEN(MAX_LEN)) decode_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_ready(item.ready),
		.item_beat(item.data),
		.res_valid(result.valid),
		.res_ready(result.ready),
		.res_beat(result.data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending),
		.n_sym(n_sym),
		.n_end(n_end),
		.n_inv(n_inv)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The result side stalls in short bursts, except in the final phase.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			result.ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			result.ready <= 1'b1;
		end
	end

	// A clear sweeps the whole table with no beat on either channel; the watchdog allows for it.
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("huffman_heap_table_decoder_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t rand_item();
		item_t it;
		it.kind = 2'($urandom_range(0, 3));
		it.code_pattern = PAT_W'($urandom());
		it.code_length = LEN_W'($urandom());
		it.symbol_value = SYM_W'($urandom());
		it.data_byte = BYTE_W'($urandom());
		return it;
	endfunction

	function automatic item_t mk(input logic [1:0] k, input logic [PAT_W-1:0] pat,
			input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym,
			input logic [BYTE_W-1:0] b);
		item_t it;
		it.kind = k;
		it.code_pattern = pat;
		it.code_length = len;
		it.symbol_value = sym;
		it.data_byte = b;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken,
	// with valid still high so that the next call can drive straight on.
	task automatic send(input item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item.valid <= 1'b1;
		item.data <= it;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
		last_kind = it.kind;
		beats_sent++;
		if (it.kind != KIND_RESERVED
				&& !(it.kind == KIND_LOAD && (it.code_length == 0 || it.code_length > MAX_LEN)))
			useful_beats++;
	endtask

	task automatic wait_idle();
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// A clear gives no result but keeps the block sweeping for a while.
		repeat (last_kind == KIND_CLEAR ? CLEAR_SWEEP + 16 : 16) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// Runs with the end symbol at 0 and MSB-first order.
	task automatic run_directed();
		send(mk(KIND_RESERVED, 12'hFFF, 4'hF, 8'hFF, 8'hFF));
		send(mk(KIND_LOAD, 12'h000, 4'd0, 8'h11, 8'h00));
		send(mk(KIND_LOAD, 12'hFFF, 4'd13, 8'h22, 8'hFF));
		send(mk(KIND_LOAD, 12'hFFF, 4'd15, 8'h44, 8'h00));
		// Pattern bits above the length are dropped: this loads code "0".
		send(mk(KIND_LOAD, 12'hFFE, 4'd1, 8'hA5, 8'h00));
		send(mk(KIND_LOAD, 12'hFFF, 4'd12, 8'h5A, 8'h00));
		send(mk(KIND_LOAD, 12'h800, 4'd12, 8'hFF, 8'h00));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'h00));
		send(mk(KIND_DATA, 12'hFFF, 4'hF, 8'hFF, 8'hFF));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'hF0));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'h80));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'h0F));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'hFF));
		// Eleven ones and a zero reach an empty leaf; the next bit runs off the table.
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'hFF));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'hE0));
		send(mk(KIND_LOAD, 12'h006, 4'd3, 8'h00, 8'h00));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'hD8));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'h00));
		send(mk(KIND_LOAD, 12'h002, 4'd2, 8'h33, 8'h00));
		send(mk(KIND_CLEAR, 12'h000, 4'd0, 8'h00, 8'h00));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'h00));
		send(mk(KIND_LOAD, 12'h001, 4'd1, 8'h80, 8'h00));
		send(mk(KIND_DATA, 12'h000, 4'd0, 8'h00, 8'h55));
	endtask

	// Loads a random prefix code and streams a run of its codewords through the
	// block, sometimes with an incomplete code, an end marker or junk bytes.
	task automatic play_sequence();
		int leaf_pat [$];
		int leaf_len [$];
		bit code_bits [$];
		int n_leaves;
		int depth_cap;
		int pick;
		int tries;
		int eof_leaf;
		int n_words;
		bit with_eof;
		bit bv;
		logic [SYM_W-1:0] sym;
		logic [BYTE_W-1:0] b;
		item_t it;
		with_eof = ($urandom_range(0, 3) == 0);
		if (stream_closed || $urandom_range(0, 5) != 0) begin
			it = rand_item();
			it.kind = KIND_CLEAR;
			send(it);
			stream_closed = 1'b0;
		end
		n_leaves = $urandom_range(3, 12);
		depth_cap = ($urandom_range(0, 3) == 0) ? MAX_LEN : 5;
		leaf_pat = '{0, 1};
		leaf_len = '{1, 1};
		tries = 0;
		while (leaf_pat.size() < n_leaves && tries < 100) begin
			tries++;
			// Splitting the newest leaf again and again grows long codewords.
			pick = ($urandom_range(0, 2) == 0) ? leaf_pat.size() - 1
				: $urandom_range(0, leaf_pat.size() - 1);
			if (leaf_len[pick] < depth_cap) begin
				leaf_pat.push_back(leaf_pat[pick] * 2 + 1);
				leaf_len.push_back(leaf_len[pick] + 1);
				leaf_pat[pick] = leaf_pat[pick] * 2;
				leaf_len[pick] = leaf_len[pick] + 1;
			end
		end
		if (leaf_pat.size() > 3 && $urandom_range(0, 4) == 0) begin
			pick = $urandom_range(0, leaf_pat.size() - 1);
			leaf_pat.delete(pick);
			leaf_len.delete(pick);
		end
		eof_leaf = with_eof ? $urandom_range(0, leaf_pat.size() - 1) : -1;
		foreach (leaf_pat[i]) begin
			sym = SYM_W'($urandom());
			if (i == eof_leaf) sym = eof_cur;
			else if (sym == eof_cur) sym ^= 8'h01;
			it = rand_item();
			it.kind = KIND_LOAD;
			it.code_length = LEN_W'(leaf_len[i]);
			it.symbol_value = sym;
			if ($urandom_range(0, 1) == 0)
				it.code_pattern = PAT_W'(leaf_pat[i]);
			else
				it.code_pattern = PAT_W'(($urandom() & ~((1 << leaf_len[i]) - 1)) | leaf_pat[i]);
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send(mk(KIND_RESERVED, PAT_W'($urandom()), LEN_W'($urandom()),
						SYM_W'($urandom()), BYTE_W'($urandom())));
				else
					send(mk(KIND_LOAD, PAT_W'($urandom()), ($urandom_range(0, 1) == 0) ? 4'd0
						: LEN_W'($urandom_range(MAX_LEN + 1, 15)), SYM_W'($urandom()),
						BYTE_W'($urandom())));
			end
			send(it);
		end
		n_words = $urandom_range(2, 10);
		repeat (n_words) begin
			do pick = $urandom_range(0, leaf_pat.size() - 1); while (pick == eof_leaf);
			for (int k = leaf_len[pick] - 1; k >= 0; k--) code_bits.push_back(leaf_pat[pick][k]);
		end
		if (with_eof)
			for (int k = leaf_len[eof_leaf] - 1; k >= 0; k--)
				code_bits.push_back(leaf_pat[eof_leaf][k]);
		while (code_bits.size() > 0) begin
			for (int j = 0; j < 8; j++) begin
				bv = (code_bits.size() > 0) ? code_bits.pop_front() : 1'($urandom_range(0, 1));
				if (lsb_cur) b[j] = bv;
				else b[7 - j] = bv;
			end
			it = rand_item();
			it.kind = KIND_DATA;
			it.data_byte = b;
			send(it);
		end
		if (with_eof || $urandom_range(0, 3) == 0) begin
			// After an end marker these bytes must be dropped; otherwise they are noise.
			repeat ($urandom_range(1, 2)) begin
				it = rand_item();
				it.kind = KIND_DATA;
				send(it);
			end
		end
		if (with_eof) stream_closed = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < N_PHASES; p++) begin
			calm = (p == N_PHASES - 1);
			if (p > 0) wait_idle();
			case (p)
				0: begin eof_cur = 8'h00; lsb_cur = 1'b0; end
				1: begin eof_cur = 8'hFF; lsb_cur = 1'b1; end
				2: begin eof_cur = SYM_W'($urandom()); lsb_cur = 1'b0; end
				3: begin eof_cur = SYM_W'($urandom()); lsb_cur = 1'b1; end
				default: begin eof_cur = SYM_W'($urandom()); lsb_cur = 1'($urandom_range(0, 1)); end
			endcase
			write_reg(CFG_EOF_SYMBOL, CFG_DATA_W'(eof_cur));
			write_reg(CFG_LSB_FIRST, CFG_DATA_W'(lsb_cur));
			cfg_we <= 1'b0;
			@(negedge clk);
			if (p == 0) run_directed();
			while (useful_beats < (p + 1) * ITEMS_PER_PHASE) play_sequence();
		end
		wait_idle();
		$display("Sent %0d item beats over %0d register settings, both bit orders included.",
			beats_sent, N_PHASES);
		$display("Checked %0d symbols, %0d end markers and %0d invalid codes; %0d mismatches.",
			n_sym, n_end, n_inv, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("huffman_heap_table_decoder_core verification clean");
		end else begin
			$display("huffman_heap_table_decoder_core verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/hht_pkg.sv
rtl/hht_stream_if.sv
rtl/hht_ram.sv
rtl/huffman_heap_table_decoder_core.sv
rtl/hht_checker.sv
test/hht_decode_checker.sv
test/testbench.sv
